// ----- sv/ghbs_pkg.sv -----
// ----------------------------------------------------------------------------
// ghbs_pkg
// Shared types and constants for the grayscale histogram bar scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package ghbs_pkg;

    localparam int NUM_BINS = 256;
    localparam int BIN_W    = 8;
    localparam int CMD_W    = 2;
    localparam int SCALE_W  = 8;
    localparam int OUT_W    = 24;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd100;

    localparam logic [CMD_W-1:0] CMD_COUNT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // control from the sequencer to the scaling unit
    typedef struct packed {
        logic start;
        logic ack;
    } div_ctl_t;

endpackage

`default_nettype wire

// ----- sv/ghbs_ram.sv -----
// ----------------------------------------------------------------------------
// ghbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ghbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/ghbs_div.sv -----
// ----------------------------------------------------------------------------
// ghbs_div
// Bit-serial bar height unit: shift-add multiply of scale by count, then
// restoring division by the maximum, one quotient bit per cycle, with
// round-to-nearest, ties to even.
// ----------------------------------------------------------------------------
`default_nettype none

module ghbs_div #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ghbs_pkg::div_ctl_t              ctl,
    input  wire logic [COUNT_BITS-1:0]           count,
    input  wire logic [COUNT_BITS-1:0]           maximum,
    input  wire logic [ghbs_pkg::SCALE_W-1:0]    scale,
    output logic                                 done,
    output logic      [ghbs_pkg::SCALE_W-1:0]    height
);

    localparam int NUMW   = COUNT_BITS + ghbs_pkg::SCALE_W;
    localparam int STEP_W = $clog2(ghbs_pkg::SCALE_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ghbs_pkg::SCALE_W - 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [1:0]                     phase_reg;
    logic [1:0]                     phase_next;
    logic [STEP_W-1:0]              step_reg;
    logic [NUMW-1:0]                rem_reg;
    logic [NUMW-1:0]                dvs_reg;
    logic [ghbs_pkg::SCALE_W-1:0]   sh_reg;
    logic [ghbs_pkg::SCALE_W-1:0]   q_reg;

    logic [NUMW:0]                  trial;
    logic [NUMW-1:0]                addend;
    logic [COUNT_BITS:0]            twice_rem;
    logic [COUNT_BITS:0]            max_ext;
    logic                           rnd_up;

    always_comb
    begin
        addend    = sh_reg[ghbs_pkg::SCALE_W-1] ? NUMW'(count) : '0;
        trial     = {1'b0, rem_reg} - {1'b0, dvs_reg};
        twice_rem = {rem_reg[COUNT_BITS-1:0], 1'b0};
        max_ext   = {1'b0, maximum};
        rnd_up    = (twice_rem > max_ext) || ((twice_rem == max_ext) && q_reg[0]);
        height    = (maximum == '0) ? '0
                  : q_reg + {{(ghbs_pkg::SCALE_W-1){1'b0}}, rnd_up};
        done      = (phase_reg == PH_DONE);
    end

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (ctl.start)
                begin
                    phase_next = PH_MUL;
                end
            end
            PH_MUL:
            begin
                if (step_reg == STEP_LAST)
                begin
                    phase_next = PH_DIV;
                end
            end
            PH_DIV:
            begin
                if (step_reg == STEP_LAST)
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
                if (ctl.ack)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (phase_reg == PH_MUL || phase_reg == PH_DIV)
            begin
                step_reg <= step_reg + 1'b1;
            end
            else
            begin
                step_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && ctl.start)
        begin
            rem_reg <= '0;
            sh_reg  <= scale;
            q_reg   <= '0;
        end
        else if (phase_reg == PH_MUL)
        begin
            rem_reg <= {rem_reg[NUMW-2:0], 1'b0} + addend;
            sh_reg  <= {sh_reg[ghbs_pkg::SCALE_W-2:0], 1'b0};
            // divisor aligned to the top quotient bit
            dvs_reg <= NUMW'(maximum) << (ghbs_pkg::SCALE_W - 1);
        end
        else if (phase_reg == PH_DIV)
        begin
            if (!trial[NUMW])
            begin
                rem_reg <= trial[NUMW-1:0];
            end
            q_reg   <= {q_reg[ghbs_pkg::SCALE_W-2:0], ~trial[NUMW]};
            dvs_reg <= {1'b0, dvs_reg[NUMW-1:1]};
        end
    end

endmodule

`default_nettype wire

// ----- sv/grayscale_histogram_bar_scaler_unit.sv -----
// ----------------------------------------------------------------------------
// grayscale_histogram_bar_scaler_unit
// 256-bin histogram of 8-bit pixels with bin queries and scaled bar heights.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  in       | in_valid / in_ready      | command, pixel, bin_index
//  out      | out_valid / out_ready    | bin_count, bar_height, largest_count
//  cfg      | cfg_wr_en (no wait)      | cfg_wr_data -> bar_scale
//
//  Count, clear and unused commands: RAM read, then update and result;
//  the read of the bin RAM is registered.
//  Query: lookup, serial multiply, serial divide, then result, with the
//  multiply and divide done by the bit-serial scaling unit.
//  Reset clears all bins at once through per-bin valid flags; no sweep.
//  A stalled output holds the block in its update step; nothing is lost.
//
`default_nettype none

module grayscale_histogram_bar_scaler_unit #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [ghbs_pkg::CMD_W-1:0]      command,
    input  wire logic [ghbs_pkg::BIN_W-1:0]      pixel,
    input  wire logic [ghbs_pkg::BIN_W-1:0]      bin_index,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [ghbs_pkg::OUT_W-1:0]      bin_count,
    output logic      [ghbs_pkg::SCALE_W-1:0]    bar_height,
    output logic      [ghbs_pkg::OUT_W-1:0]      largest_count,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ghbs_pkg::SCALE_W-1:0]    cfg_wr_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [1:0]                         state_reg;
    logic [1:0]                         state_next;
    logic [ghbs_pkg::CMD_W-1:0]         cmd_reg;
    logic [ghbs_pkg::BIN_W-1:0]         addr_reg;
    logic [COUNT_BITS-1:0]              count_reg;
    logic [COUNT_BITS-1:0]              max_reg;
    logic [ghbs_pkg::SCALE_W-1:0]       scale_reg;
    logic [ghbs_pkg::NUM_BINS-1:0]      valid_reg;
    logic                               out_valid_reg;
    logic [ghbs_pkg::OUT_W-1:0]         bin_count_reg;
    logic [ghbs_pkg::SCALE_W-1:0]       bar_height_reg;
    logic [ghbs_pkg::OUT_W-1:0]         largest_count_reg;

    logic                               accept;
    logic                               out_free;
    logic                               in_lookup;
    logic                               ram_we;
    logic [COUNT_BITS-1:0]              rd_data;
    logic [COUNT_BITS-1:0]              lookup_val;
    logic [COUNT_BITS-1:0]              inc_val;
    logic [COUNT_BITS-1:0]              max_inc;
    logic [ghbs_pkg::BIN_W-1:0]         rd_addr;
    logic                               load_out;
    logic [COUNT_BITS-1:0]              res_count;
    logic [ghbs_pkg::SCALE_W-1:0]       res_height;
    logic [COUNT_BITS-1:0]              res_max;
    logic [31:0]                        res_count_w;
    logic [31:0]                        res_max_w;
    ghbs_pkg::div_ctl_t                 div_ctl;
    logic                               div_done;
    logic [ghbs_pkg::SCALE_W-1:0]       div_height;

    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        accept     = in_valid && in_ready;
        out_free   = !out_valid_reg || out_ready;
        in_lookup  = (state_reg == ST_LOOKUP);
        rd_addr    = (command == ghbs_pkg::CMD_QUERY) ? bin_index : pixel;

        // bins not written since the last clear read as zero
        lookup_val = valid_reg[addr_reg] ? rd_data : '0;
        inc_val    = (lookup_val == CNT_MAX) ? lookup_val : lookup_val + 1'b1;
        max_inc    = (inc_val > max_reg) ? inc_val : max_reg;

        ram_we     = in_lookup && (cmd_reg == ghbs_pkg::CMD_COUNT) && out_free;

        div_ctl.start = in_lookup && (cmd_reg == ghbs_pkg::CMD_QUERY);
        div_ctl.ack   = (state_reg == ST_DIV) && div_done && out_free;

        load_out = (in_lookup && (cmd_reg != ghbs_pkg::CMD_QUERY) && out_free)
                 || div_ctl.ack;

        res_count  = '0;
        res_height = '0;
        res_max    = max_reg;
        if (state_reg == ST_DIV)
        begin
            res_count  = count_reg;
            res_height = div_height;
        end
        else if (cmd_reg == ghbs_pkg::CMD_COUNT)
        begin
            res_max = max_inc;
        end
        else if (cmd_reg == ghbs_pkg::CMD_CLEAR)
        begin
            res_max = '0;
        end
        res_count_w = 32'(res_count);
        res_max_w   = 32'(res_max);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (cmd_reg == ghbs_pkg::CMD_QUERY)
                begin
                    state_next = ST_DIV;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_ctl.ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_reg       <= '0;
            scale_reg     <= ghbs_pkg::SCALE_RESET;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                scale_reg <= cfg_wr_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_lookup && out_free)
            begin
                if (cmd_reg == ghbs_pkg::CMD_COUNT)
                begin
                    valid_reg[addr_reg] <= 1'b1;
                    max_reg             <= max_inc;
                end
                else if (cmd_reg == ghbs_pkg::CMD_CLEAR)
                begin
                    valid_reg <= '0;
                    max_reg   <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            addr_reg <= rd_addr;
        end
        if (div_ctl.start)
        begin
            count_reg <= lookup_val;
        end
        if (load_out)
        begin
            bin_count_reg     <= res_count_w[ghbs_pkg::OUT_W-1:0];
            bar_height_reg    <= res_height;
            largest_count_reg <= res_max_w[ghbs_pkg::OUT_W-1:0];
        end
    end

    ghbs_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (ghbs_pkg::NUM_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (inc_val),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    ghbs_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (div_ctl),
        .count   (count_reg),
        .maximum (max_reg),
        .scale   (scale_reg),
        .done    (div_done),
        .height  (div_height)
    );

    assign out_valid     = out_valid_reg;
    assign bin_count     = bin_count_reg;
    assign bar_height    = bar_height_reg;
    assign largest_count = largest_count_reg;

endmodule

`default_nettype wire

// ----- sv/ghbs_checker.sv -----
// ----------------------------------------------------------------------------
// ghbs_checker
// Port-level checks for the histogram bar scaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ghbs_checker #(
    parameter int COUNT_BITS = 24
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_ready,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [ghbs_pkg::OUT_W-1:0]      bin_count,
    input wire logic [ghbs_pkg::SCALE_W-1:0]    bar_height,
    input wire logic [ghbs_pkg::OUT_W-1:0]      largest_count
);

    localparam bit NARROW = (COUNT_BITS <= ghbs_pkg::OUT_W);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bin_count)
            && $stable(bar_height) && $stable(largest_count))
        else $error("result changed while stalled");

    // one transaction in flight: input closes right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // no bin exceeds the running maximum
    a_count_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && NARROW |-> bin_count <= largest_count)
        else $error("bin count above maximum");

    // a nonzero bar needs a nonzero count
    a_height_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && NARROW && (bar_height != '0) |-> bin_count != '0)
        else $error("bar height without count");

endmodule

bind grayscale_histogram_bar_scaler_unit ghbs_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_ghbs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .bin_count     (bin_count),
    .bar_height    (bar_height),
    .largest_count (largest_count)
);

`default_nettype wire

// ----- dv/grayscale_histogram_bar_scaler_unit_tb.sv -----
// ----------------------------------------------------------------------------
// grayscale_histogram_bar_scaler_unit_tb
// Self-checking bench for the histogram bar scaler. A short directed sequence
// covers the empty histogram, rounding ties, the unused command and clear.
// Random phases with pixel, query and clear traffic follow, each under a new
// bar scale. Input bursts and output stalls are random. Every result is
// compared with an in-bench histogram model.
// ----------------------------------------------------------------------------

module grayscale_histogram_bar_scaler_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CMD_W    = ghbs_pkg::CMD_W;
    localparam int BIN_W    = ghbs_pkg::BIN_W;
    localparam int SCALE_W  = ghbs_pkg::SCALE_W;
    localparam int OUT_W    = ghbs_pkg::OUT_W;
    localparam int NUM_BINS = ghbs_pkg::NUM_BINS;

    // counter width as the block's default
    localparam int COUNT_BITS = 24;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int PHASES     = 6;
    localparam int SAT_PHASE  = 1;
    localparam int SETTLE_CYC = 24;
    localparam int MAX_PRINTS = 50;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [BIN_W-1:0] pixel;
        logic [BIN_W-1:0] bin_index;
    } pixel_op_t;

    typedef struct packed {
        logic [OUT_W-1:0]   bin_count;
        logic [SCALE_W-1:0] bar_height;
        logic [OUT_W-1:0]   largest_count;
    } bar_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [CMD_W-1:0]   command = ghbs_pkg::CMD_COUNT;
    logic [BIN_W-1:0]   pixel = '0;
    logic [BIN_W-1:0]   bin_index = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [OUT_W-1:0]   bin_count;
    logic [SCALE_W-1:0] bar_height;
    logic [OUT_W-1:0]   largest_count;
    logic               cfg_wr_en = 1'b0;
    logic [SCALE_W-1:0] cfg_wr_data = '0;

    grayscale_histogram_bar_scaler_unit #(
        .COUNT_BITS(COUNT_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .pixel         (pixel),
        .bin_index     (bin_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .bin_count     (bin_count),
        .bar_height    (bar_height),
        .largest_count (largest_count),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // histogram model
    logic [COUNT_BITS-1:0] bin_model [NUM_BINS];
    logic [COUNT_BITS-1:0] peak_model;
    logic [SCALE_W-1:0]    scale_model;

    pixel_op_t   pending_ops[$];
    bar_result_t expected_bars[$];

    int n_errors = 0;
    int n_results = 0;
    int n_count = 0;
    int n_query = 0;
    int n_clear = 0;
    int n_unused = 0;
    int n_saturated = 0;
    int n_ties = 0;
    int n_zero_scale = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("ERROR %0t ns result %0d: %s = %0d, expected %0d",
                     $time, n_results, what, got, want);
    endtask

    // update the model with one accepted transaction and queue its result
    task automatic histogram_update(input pixel_op_t op);
        bar_result_t           res;
        logic [COUNT_BITS-1:0] cnt;
        longint unsigned       num, quo, rem;
        res = '0;
        case (op.command)
            ghbs_pkg::CMD_COUNT:
            begin
                n_count++;
                cnt = bin_model[op.pixel];
                if (cnt != '1)
                    cnt = cnt + 1'b1;
                else
                    n_saturated++;
                bin_model[op.pixel] = cnt;
                if (cnt > peak_model)
                    peak_model = cnt;
            end
            ghbs_pkg::CMD_QUERY:
            begin
                n_query++;
                if (scale_model == '0)
                    n_zero_scale++;
                cnt = bin_model[op.bin_index];
                res.bin_count = OUT_W'(cnt);
                if (peak_model != '0)
                begin
                    num = 64'(scale_model);
                    num = num * 64'(cnt);
                    quo = num / 64'(peak_model);
                    rem = num % 64'(peak_model);
                    if (2 * rem == 64'(peak_model))
                        n_ties++;
                    // round half to even
                    if (2 * rem > 64'(peak_model)
                        || (2 * rem == 64'(peak_model) && quo[0]))
                        quo++;
                    res.bar_height = SCALE_W'(quo);
                end
            end
            ghbs_pkg::CMD_CLEAR:
            begin
                n_clear++;
                foreach (bin_model[i])
                    bin_model[i] = '0;
                peak_model = '0;
            end
            default:
                n_unused++;
        endcase
        res.largest_count = OUT_W'(peak_model);
        expected_bars.push_back(res);
    endtask

    // input driver: bursts of transactions separated by random gaps
    pixel_op_t cur_op;
    int        burst_left;
    int        gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        int roll;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                histogram_update(cur_op);
            if (in_valid && !in_ready)
            begin
                // hold payload until accepted
            end
            else if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_ops.size() != 0)
            begin
                cur_op    = pending_ops.pop_front();
                command   <= cur_op.command;
                pixel     <= cur_op.pixel;
                bin_index <= cur_op.bin_index;
                in_valid  <= 1'b1;
                if (burst_left <= 1)
                begin
                    roll = $urandom_range(0, 9);
                    burst_left <= $urandom_range(1, 40);
                    if (roll < 3)
                        gap_left <= 0;
                    else if (roll < 8)
                        gap_left <= $urandom_range(1, 6);
                    else
                        gap_left <= $urandom_range(7, 30);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output monitor with its own stall pattern
    int stall_mode;
    int stall_left;

    always @(posedge clk or negedge rst_n)
    begin
        bar_result_t want;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_mode <= 0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (expected_bars.size() == 0)
                begin
                    report_mismatch("unexpected result, largest_count",
                                    32'(largest_count), 32'd0);
                end
                else
                begin
                    want = expected_bars.pop_front();
                    if (bin_count !== want.bin_count)
                        report_mismatch("bin_count", 32'(bin_count),
                                        32'(want.bin_count));
                    if (bar_height !== want.bar_height)
                        report_mismatch("bar_height", 32'(bar_height),
                                        32'(want.bar_height));
                    if (largest_count !== want.largest_count)
                        report_mismatch("largest_count", 32'(largest_count),
                                        32'(want.largest_count));
                end
            end
            if (stall_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                stall_left <= $urandom_range(32, 200);
            end
            else
            begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 9) < 7);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // wait until the block is idle with nothing outstanding
    task automatic drain_block();
        while (pending_ops.size() != 0 || in_valid || expected_bars.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_bar_scale(input logic [SCALE_W-1:0] scale);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= scale;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        scale_model = scale;
    endtask

    task automatic push_op(input logic [CMD_W-1:0] cmd, input logic [BIN_W-1:0] pix,
                           input logic [BIN_W-1:0] idx);
        pixel_op_t op;
        op.command   = cmd;
        op.pixel     = pix;
        op.bin_index = idx;
        pending_ops.push_back(op);
    endtask

    initial
    begin
        logic [SCALE_W-1:0] scales [PHASES];
        logic [BIN_W-1:0]   hot [4];
        pixel_op_t          op;
        int                 n_items;
        int                 roll;

        foreach (bin_model[i])
            bin_model[i] = '0;
        peak_model  = '0;
        scale_model = ghbs_pkg::SCALE_RESET;

        scales[0] = 8'd255;
        scales[1] = 8'd1;
        scales[2] = 8'd0;
        scales[3] = SCALE_W'($urandom_range(2, 254));
        scales[4] = 8'd128;
        scales[5] = 8'd200;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty query, unused command, ties to even at scale 100
        push_op(ghbs_pkg::CMD_QUERY, 8'h00, 8'h00);
        push_op(CMD_UNUSED, 8'hFF, 8'hFF);
        repeat (8) push_op(ghbs_pkg::CMD_COUNT, 8'h80, 8'h00);
        push_op(ghbs_pkg::CMD_COUNT, 8'h00, 8'hFF);
        repeat (3) push_op(ghbs_pkg::CMD_COUNT, 8'hFF, 8'h00);
        push_op(ghbs_pkg::CMD_QUERY, 8'hFF, 8'h00);   // 12.5 rounds down
        push_op(ghbs_pkg::CMD_QUERY, 8'h00, 8'hFF);   // 37.5 rounds up
        push_op(ghbs_pkg::CMD_QUERY, 8'h00, 8'h80);   // full scale
        push_op(ghbs_pkg::CMD_QUERY, 8'h00, 8'h55);
        push_op(CMD_UNUSED, 8'h00, 8'h00);
        push_op(ghbs_pkg::CMD_CLEAR, 8'h5A, 8'hA5);
        push_op(ghbs_pkg::CMD_QUERY, 8'h00, 8'h80);
        push_op(ghbs_pkg::CMD_COUNT, 8'hAA, 8'h00);
        push_op(ghbs_pkg::CMD_QUERY, 8'h00, 8'hAA);
        drain_block();

        for (int p = 0; p < PHASES; p++)
        begin
            write_bar_scale(scales[p]);
            foreach (hot[k])
                hot[k] = BIN_W'($urandom);
            n_items = (p == SAT_PHASE) ? 420 : 302;
            for (int n = 0; n < n_items; n++)
            begin
                roll         = $urandom_range(0, 99);
                op.command   = ghbs_pkg::CMD_COUNT;
                op.pixel     = BIN_W'($urandom);
                op.bin_index = BIN_W'($urandom);
                if (p == SAT_PHASE)
                begin
                    // hammer one bin to build a tall peak
                    if (roll < 90)
                    begin
                        op.pixel = hot[0];
                    end
                    else if (roll < 97)
                    begin
                        op.command = ghbs_pkg::CMD_QUERY;
                        if (roll[0])
                            op.bin_index = hot[0];
                    end
                end
                else
                begin
                    if (roll < 35)
                    begin
                        op.pixel = hot[$urandom_range(0, 3)];
                    end
                    else if (roll < 65)
                    begin
                        // count on a random pixel
                    end
                    else if (roll < 94)
                    begin
                        op.command = ghbs_pkg::CMD_QUERY;
                        if (roll < 82)
                            op.bin_index = hot[$urandom_range(0, 3)];
                    end
                    else if (roll < 96)
                    begin
                        op.command = ghbs_pkg::CMD_CLEAR;
                    end
                    else
                    begin
                        op.command = CMD_UNUSED;
                    end
                end
                pending_ops.push_back(op);
            end
            drain_block();
        end

        $display("Run covered %0d transactions: %0d counts, %0d queries,",
                 n_count + n_query + n_clear + n_unused, n_count, n_query);
        $display("  %0d clears, %0d unused; %0d results checked, %0d saturated counts,",
                 n_clear, n_unused, n_results, n_saturated);
        $display("  %0d rounding ties, %0d zero-scale queries", n_ties, n_zero_scale);
        if (n_errors == 0 && expected_bars.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("Timeout with %0d results outstanding", expected_bars.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
